// ===== design/cttok_pkg.sv =====
// ----------------------------------------------------------------------------
// cttok_pkg
// Types, codes and character helpers shared by the config text tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cttok_pkg;

  // input beat: one text byte or an end marker
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_flag;
  } in_t;

  // output beat: one lexer event
  typedef struct packed {
    logic [1:0] event_kind;
    logic [3:0] token_kind;
    logic [7:0] char_out;
    logic       abandoned;
    logic       last_of_run;
  } out_t;

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_DONE  = 2'd1,
    EV_PUNCT = 2'd2,
    EV_END   = 2'd3
  } event_e;

  typedef enum logic [5:0] {
    MODE_SKIP    = 6'b000001,
    MODE_SLASH   = 6'b000010,
    MODE_COMMENT = 6'b000100,
    MODE_IDENT   = 6'b001000,
    MODE_STRING  = 6'b010000,
    MODE_STRESC  = 6'b100000
  } mode_e;

  localparam logic [3:0] TK_IDENT  = 4'd0;
  localparam logic [3:0] TK_STRING = 4'd1;
  localparam logic [3:0] TK_NONE   = 4'd0;
  localparam logic [3:0] TK_LPAREN = 4'd2;
  localparam logic [3:0] TK_RPAREN = 4'd3;
  localparam logic [3:0] TK_LBRACE = 4'd4;
  localparam logic [3:0] TK_RBRACE = 4'd5;
  localparam logic [3:0] TK_LBRACK = 4'd6;
  localparam logic [3:0] TK_RBRACK = 4'd7;
  localparam logic [3:0] TK_HYPHEN = 4'd8;
  localparam logic [3:0] TK_COMMA  = 4'd9;
  localparam logic [3:0] TK_COLON  = 4'd10;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDERLINE = 8'h5F;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  // punctuation code, TK_NONE when the byte is not punctuation
  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    unique case (c)
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h7B:   k = TK_LBRACE;
      8'h7D:   k = TK_RBRACE;
      8'h5B:   k = TK_LBRACK;
      8'h5D:   k = TK_RBRACK;
      8'h2D:   k = TK_HYPHEN;
      8'h2C:   k = TK_COMMA;
      8'h3A:   k = TK_COLON;
      default: k = TK_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== design/cttok_decode.sv =====
// ----------------------------------------------------------------------------
// cttok_decode
// Lexer step: from the current mode and one input beat, the events it causes
// (up to two) and the next mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cttok_decode (
  input  cttok_pkg::mode_e mode_i,
  input  cttok_pkg::in_t   item_i,
  output cttok_pkg::out_t  res0_o,
  output cttok_pkg::out_t  res1_o,
  output logic [1:0]       num_o,
  output cttok_pkg::mode_e mode_o
);

  logic [7:0]       c;
  logic [3:0]       pk;
  logic             c_letter;
  cttok_pkg::out_t  sk_res;
  logic             sk_emit;
  cttok_pkg::mode_e sk_mode;
  cttok_pkg::out_t  byte_res;
  cttok_pkg::out_t  r0;
  cttok_pkg::out_t  r1;
  logic [1:0]       n;
  logic             open_tok;

  assign c        = item_i.text_byte;
  assign pk       = cttok_pkg::punct_kind(c);
  assign c_letter = cttok_pkg::is_letter(c);
  assign open_tok = (mode_i == cttok_pkg::MODE_IDENT) ||
                    (mode_i == cttok_pkg::MODE_STRING) ||
                    (mode_i == cttok_pkg::MODE_STRESC);

  // handling of a byte seen between tokens
  always_comb begin
    sk_res  = '0;
    sk_emit = 1'b0;
    sk_mode = cttok_pkg::MODE_SKIP;
    priority if (c_letter) begin
      sk_mode            = cttok_pkg::MODE_IDENT;
      sk_emit            = 1'b1;
      sk_res.event_kind  = cttok_pkg::EV_BYTE;
      sk_res.token_kind  = cttok_pkg::TK_IDENT;
      sk_res.char_out    = c;
    end else if (c == cttok_pkg::CH_QUOTE) begin
      sk_mode = cttok_pkg::MODE_STRING;
    end else if (pk != cttok_pkg::TK_NONE) begin
      sk_emit           = 1'b1;
      sk_res.event_kind = cttok_pkg::EV_PUNCT;
      sk_res.token_kind = pk;
    end else if (c == cttok_pkg::CH_SLASH) begin
      sk_mode = cttok_pkg::MODE_SLASH;
    end else begin
      sk_mode = cttok_pkg::MODE_SKIP;
    end
  end

  always_comb begin
    byte_res            = '0;
    byte_res.event_kind = cttok_pkg::EV_BYTE;
    byte_res.token_kind = (mode_i == cttok_pkg::MODE_IDENT) ? cttok_pkg::TK_IDENT
                                                             : cttok_pkg::TK_STRING;
    byte_res.char_out   = c;
  end

  always_comb begin
    r0     = '0;
    r1     = '0;
    n      = 2'd0;
    mode_o = mode_i;
    if (item_i.end_flag) begin
      r0.event_kind = cttok_pkg::EV_END;
      r0.abandoned  = open_tok;
      n             = 2'd1;
      mode_o        = cttok_pkg::MODE_SKIP;
    end else begin
      unique case (mode_i)
        cttok_pkg::MODE_SLASH: begin
          if (c == cttok_pkg::CH_SLASH) begin
            mode_o = cttok_pkg::MODE_COMMENT;
          end else begin
            r0     = sk_res;
            n      = {1'b0, sk_emit};
            mode_o = sk_mode;
          end
        end
        cttok_pkg::MODE_COMMENT: begin
          if (c == cttok_pkg::CH_NEWLINE) begin
            mode_o = cttok_pkg::MODE_SKIP;
          end
        end
        cttok_pkg::MODE_IDENT: begin
          if (c_letter || (c == cttok_pkg::CH_UNDERLINE)) begin
            r0 = byte_res;
            n  = 2'd1;
          end else begin
            // identifier ends; the ending byte is then seen as between tokens
            r0.event_kind = cttok_pkg::EV_DONE;
            r0.token_kind = cttok_pkg::TK_IDENT;
            r1            = sk_res;
            n             = sk_emit ? 2'd2 : 2'd1;
            mode_o        = sk_mode;
          end
        end
        cttok_pkg::MODE_STRING: begin
          priority if (c == cttok_pkg::CH_QUOTE) begin
            r0.event_kind = cttok_pkg::EV_DONE;
            r0.token_kind = cttok_pkg::TK_STRING;
            n             = 2'd1;
            mode_o        = cttok_pkg::MODE_SKIP;
          end else if (c == cttok_pkg::CH_BACKSLASH) begin
            mode_o = cttok_pkg::MODE_STRESC;
          end else if (c != cttok_pkg::CH_NEWLINE) begin
            r0 = byte_res;
            n  = 2'd1;
          end else begin
            mode_o = cttok_pkg::MODE_STRING;
          end
        end
        cttok_pkg::MODE_STRESC: begin
          // newline is dropped even when escaped
          if (c != cttok_pkg::CH_NEWLINE) begin
            r0 = byte_res;
            n  = 2'd1;
          end
          mode_o = cttok_pkg::MODE_STRING;
        end
        default: begin
          r0     = sk_res;
          n      = {1'b0, sk_emit};
          mode_o = sk_mode;
        end
      endcase
    end

    // mark the final event of this beat
    priority if (n == 2'd2) begin
      r1.last_of_run = 1'b1;
    end else if (n == 2'd1) begin
      r0.last_of_run = 1'b1;
    end else begin
      r0.last_of_run = 1'b0;
    end
  end

  assign res0_o = r0;
  assign res1_o = r1;
  assign num_o  = n;

endmodule

`default_nettype wire

// ===== design/cttok_outq.sv =====
// ----------------------------------------------------------------------------
// cttok_outq
// Two-slot result register; takes up to two events at once and hands them out
// one beat at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cttok_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cttok_pkg::out_t res0_i,
  input  cttok_pkg::out_t res1_i,
  input  logic [1:0]      num_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cttok_pkg::out_t out_data_o
);

  cttok_pkg::out_t slot0_q, slot0_d;
  cttok_pkg::out_t slot1_q, slot1_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot0_q;
  assign pop         = out_valid_o && out_ready_i;
  // a new beat may enter once the buffer drains this cycle
  assign space_o     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    priority if (push_i) begin
      slot0_d = res0_i;
      slot1_d = res1_i;
      cnt_d   = num_i;
    end else if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result count out of range");

  a_push_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop)))
    else $error("push onto a buffer that still holds results");

  a_lone_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> slot0_q.last_of_run)
    else $error("single held result is not marked last");

  a_drain_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q == 2'd2) && pop) |=> (cnt_q == 2'd1))
    else $error("second result lost after first beat");

endmodule

`default_nettype wire

// ===== design/config_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// config_text_tokenizer
// Streaming lexer for a small configuration text language.
//
//   channel | direction | handshake               | beat
//   in      | input     | in_valid_i / in_ready_o   | in_t  (byte or end marker)
//   out     | output    | out_valid_o / out_ready_i | out_t (one lexer event)
//
// events of a beat accepted at one edge appear on the output from the next cycle
// a beat that gives one event or none sustains one beat per cycle unless the
// output stalls; a beat that gives two events (identifier closed by punctuation)
// holds the input while the second event drains from the two-slot buffer
// reset returns the lexer to skip mode and empties the result register
// in_ready_o follows out_ready_i combinationally when one event is held
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module config_text_tokenizer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cttok_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cttok_pkg::out_t out_data_o
);

  cttok_pkg::mode_e mode_q, mode_d;
  cttok_pkg::mode_e mode_next;
  cttok_pkg::out_t  res0;
  cttok_pkg::out_t  res1;
  logic [1:0]       num;
  logic             space;
  logic             accept;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;
  assign mode_d     = accept ? mode_next : mode_q;

  cttok_decode u_decode (
    .mode_i (mode_q),
    .item_i (in_data_i),
    .res0_o (res0),
    .res1_o (res1),
    .num_o  (num),
    .mode_o (mode_next)
  );

  cttok_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res0_i      (res0),
    .res1_i      (res1),
    .num_i       (num),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cttok_pkg::MODE_SKIP;
    end else begin
      mode_q <= mode_d;
    end
  end

endmodule

`default_nettype wire
